### src/tsp_exhaustive_tour_search_unit_assert.svh
// Assertion macros for the tour search unit
`ifndef TSP_EXHAUSTIVE_TOUR_SEARCH_UNIT_ASSERT_SVH
`define TSP_EXHAUSTIVE_TOUR_SEARCH_UNIT_ASSERT_SVH
`define TSP_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TSP_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the exhaustive tour search unit.
// ----------------------------------------------------------------------------
package tsp_pkg;
    localparam int MAX_CITIES = 8;
    localparam int COST_BITS  = 16;
    localparam int CITY_W  = 3;
    localparam int TOTAL_W = 20;
    localparam int NCFG_W  = 4;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [2:0]  from_city;
        logic [2:0]  to_city;
        logic [15:0] edge_cost;
    } tsp_in_t;

    typedef struct packed {
        logic [2:0]  city;
        logic [19:0] tour_cost;
        logic        last;
    } tsp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_ACC, ST_CMP, ST_SCAN, ST_PERM, ST_EMIT
    } tsp_state_t;
endpackage

### src/tsp_ram.sv
// ----------------------------------------------------------------------------
// tsp_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/tsp_exhaustive_tour_search_unit.sv
// ----------------------------------------------------------------------------
// tsp_exhaustive_tour_search_unit
// Brute-force tour search: cost matrix in a RAM, one shared adder/comparator
// walked by a sequencer over all city orders that start at city 0, in lexicographic order.
// ----------------------------------------------------------------------------
// A solve keeps busy high while every tour is scored: each edge is one RAM
// read (ST_READ) plus one add (ST_ACC), and each tour adds a compare (ST_CMP)
// and a permutation step (ST_SCAN, ST_PERM); the solve time is set by the
// single RAM read port and the shared adder. The tour then comes out as N+1
// beats on consecutive cycles, one strobe per beat; the receiver cannot stall
// them.
module tsp_exhaustive_tour_search_unit
    import tsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [NCFG_W-1:0]   cfg_wdata,
    input  logic                start,
    input  tsp_in_t             in_item,
    output logic                busy,
    output logic                strobe,
    output tsp_out_t            result
);
    localparam int IW = $clog2(MAX_CITIES);
    localparam int AW = 2 * IW;

    tsp_state_t       state_reg, state_next;
    logic [NCFG_W-1:0] ncfg_reg;
    logic [IW-1:0]    ord_reg [MAX_CITIES];
    logic [IW-1:0]    ord_next [MAX_CITIES];
    logic [IW-1:0]    best_reg [MAX_CITIES];
    logic [IW-1:0]    best_next [MAX_CITIES];
    logic [NCFG_W-1:0] n_reg, n_next;
    logic [NCFG_W-1:0] k_reg, k_next;
    logic [NCFG_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [1:0]       ph_reg, ph_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next, bt_reg, bt_next;
    logic             first_reg, first_next;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [COST_BITS-1:0] wdata, rdata;
    logic [IW-1:0]    a_c, b_c;
    logic [NCFG_W-1:0] nsat;

    always_comb
    begin
        if (ncfg_reg == '0)
            nsat = NCFG_W'(1);
        else if (32'(ncfg_reg) > MAX_CITIES)
            nsat = NCFG_W'(MAX_CITIES);
        else
            nsat = ncfg_reg;
    end

    assign we = start && !busy && in_item.command == CMD_WRITE
                && 32'(in_item.from_city) < MAX_CITIES && 32'(in_item.to_city) < MAX_CITIES;
    assign waddr = {IW'(in_item.from_city), IW'(in_item.to_city)};
    assign wdata = COST_BITS'(in_item.edge_cost);
    assign a_c = ord_reg[k_reg[IW-1:0]];
    assign b_c = (k_reg + 1'b1 == n_reg) ? ord_reg[0] : ord_reg[IW'(k_reg + 1'b1)];
    assign raddr = {a_c, b_c};

    tsp_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_CITIES * MAX_CITIES)) u_cost (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ncfg_reg  <= NCFG_W'(8);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                ncfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg   <= ord_next;
        best_reg  <= best_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        ph_reg    <= ph_next;
        sum_reg   <= sum_next;
        bt_reg    <= bt_next;
        first_reg <= first_next;
    end

    always_comb
    begin
        logic [IW-1:0] t;
        state_next = state_reg;
        ord_next   = ord_reg;
        best_next  = best_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ph_next    = ph_reg;
        sum_next   = sum_reg;
        bt_next    = bt_reg;
        first_next = first_reg;
        busy       = (state_reg != ST_IDLE);
        strobe     = 1'b0;
        result     = '0;
        t          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && in_item.command == CMD_SOLVE)
                begin
                    n_next = nsat;
                    for (int m = 0; m < MAX_CITIES; m++)
                    begin
                        ord_next[m] = IW'(m);
                    end
                    k_next     = '0;
                    sum_next   = '0;
                    first_next = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sum_next = sum_reg + TOTAL_W'(rdata);
                if (k_reg + 1'b1 == n_reg)
                    state_next = ST_CMP;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_CMP:
            begin
                if (first_reg || sum_reg < bt_reg)
                begin
                    best_next  = ord_reg;
                    bt_next    = sum_reg;
                    first_next = 1'b0;
                end
                if (n_reg < NCFG_W'(3))
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next     = n_reg - 1'b1;
                    ph_next    = 2'd0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (i_reg > NCFG_W'(1)
                    && ord_reg[IW'(i_reg - 1'b1)] >= ord_reg[i_reg[IW-1:0]])
                    i_next = i_reg - 1'b1;
                else if (i_reg <= NCFG_W'(1))
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    j_next     = n_reg - 1'b1;
                    ph_next    = 2'd1;
                    state_next = ST_PERM;
                end
            end
            ST_PERM:
            begin
                if (ph_reg == 2'd1)
                begin
                    if (ord_reg[j_reg[IW-1:0]] <= ord_reg[IW'(i_reg - 1'b1)])
                        j_next = j_reg - 1'b1;
                    else
                    begin
                        t = ord_reg[IW'(i_reg - 1'b1)];
                        ord_next[IW'(i_reg - 1'b1)] = ord_reg[j_reg[IW-1:0]];
                        ord_next[j_reg[IW-1:0]] = t;
                        j_next  = n_reg - 1'b1;
                        ph_next = 2'd2;
                    end
                end
                else
                begin
                    if (i_reg < j_reg)
                    begin
                        t = ord_reg[i_reg[IW-1:0]];
                        ord_next[i_reg[IW-1:0]] = ord_reg[j_reg[IW-1:0]];
                        ord_next[j_reg[IW-1:0]] = t;
                        i_next = i_reg + 1'b1;
                        j_next = j_reg - 1'b1;
                    end
                    else
                    begin
                        k_next     = '0;
                        sum_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                strobe = 1'b1;
                result.city = (k_reg == n_reg) ? '0 : CITY_W'(best_reg[k_reg[IW-1:0]]);
                result.tour_cost = bt_reg;
                result.last = (k_reg == n_reg);
                if (k_reg == n_reg)
                    state_next = ST_IDLE;
                else
                    k_next = k_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### src/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tour search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "tsp_exhaustive_tour_search_unit_assert.svh"
module tsp_checker
    import tsp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     busy,
    input logic     strobe,
    input tsp_out_t result
);
    `TSP_ASSERT_IMPL(a_strobe_busy, strobe, busy)
    `TSP_ASSERT_NEXT(a_last_ends, strobe && result.last, !busy)
    `TSP_ASSERT_NEXT(a_beat_cont, strobe && !result.last, strobe)
    `TSP_ASSERT_NEXT(a_cost_hold, strobe && !result.last, result.tour_cost == $past(result.tour_cost))
    `TSP_ASSERT_IMPL(a_last_city, strobe && result.last, result.city == '0)
endmodule

bind tsp_exhaustive_tour_search_unit tsp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy), .strobe(strobe), .result(result)
);

### tb/tb_tsp_exhaustive_tour_search_unit.sv
// ----------------------------------------------------------------------------
// tb_tsp_exhaustive_tour_search_unit
// Self-checking bench for the exhaustive tour search unit: loads cost
// matrices, runs solves over several city counts, and compares every tour
// beat against a behavioral brute-force search.
// ----------------------------------------------------------------------------
module tb_tsp_exhaustive_tour_search_unit
    import tsp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = 8;
    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int IN_W = $bits(tsp_in_t);

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic [NCFG_W-1:0] cfg_wdata;
    logic     start;
    tsp_in_t  in_item;
    logic     busy;
    logic     strobe;
    tsp_out_t result;

    tsp_exhaustive_tour_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .in_item   (in_item),
        .busy      (busy),
        .strobe    (strobe),
        .result    (result)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    logic [15:0]       cost_mat [NMAX][NMAX];
    bit                cost_set [NMAX][NMAX];
    logic [NCFG_W-1:0] city_count_reg;
    tsp_out_t          tour_beats_q [$];
    int                errors;
    int                idle_cycles;
    bit                start_held;

    typedef struct {
        tsp_in_t  beat;
        bit       has_fixed;
        logic [19:0] fixed_cost;
    } vec_t;

    function automatic int eff_cities();
        int n;
        n = city_count_reg;
        if (n < 1) n = 1;
        if (n > NMAX) n = NMAX;
        return n;
    endfunction

    function automatic bit next_order(ref logic [2:0] ord [NMAX], input int n);
        int i, j, lo, hi;
        logic [2:0] t;
        if (n < 3) return 0;
        i = n - 1;
        while (i > 1 && ord[i-1] >= ord[i]) i--;
        if (i <= 1) return 0;
        j = n - 1;
        while (ord[j] <= ord[i-1]) j--;
        t = ord[i-1]; ord[i-1] = ord[j]; ord[j] = t;
        lo = i; hi = n - 1;
        while (lo < hi)
        begin
            t = ord[lo]; ord[lo] = ord[hi]; ord[hi] = t;
            lo++; hi--;
        end
        return 1;
    endfunction

    task automatic predict_tour(input tsp_in_t beat);
        logic [2:0]  ord [NMAX];
        logic [2:0]  best [NMAX];
        logic [19:0] sum, best_sum;
        bit          first;
        int          n;
        tsp_out_t    r;
        if (beat.command == CMD_WRITE)
        begin
            cost_mat[beat.from_city][beat.to_city] = beat.edge_cost;
            cost_set[beat.from_city][beat.to_city] = 1;
            return;
        end
        n = eff_cities();
        for (int k = 0; k < NMAX; k++) ord[k] = 3'(k);
        first = 1;
        best_sum = '1;
        do
        begin
            sum = 0;
            for (int k = 0; k + 1 < n; k++) sum += cost_mat[ord[k]][ord[k+1]];
            sum += cost_mat[ord[n-1]][ord[0]];
            if (first || sum < best_sum)
            begin
                best = ord;
                best_sum = sum;
                first = 0;
            end
        end
        while (next_order(ord, n));
        for (int k = 0; k <= n; k++)
        begin
            r.city = (k < n) ? best[k] : 3'd0;
            r.tour_cost = best_sum;
            r.last = (k == n);
            tour_beats_q.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        tsp_out_t exp_beat;
        if (rst_n && strobe)
        begin
            if (tour_beats_q.size() == 0)
            begin
                $display("%0t: unexpected beat city=%0d cost=%0d last=%0b",
                         $time, result.city, result.tour_cost, result.last);
                errors++;
            end
            else
            begin
                exp_beat = tour_beats_q.pop_front();
                if (result.city !== exp_beat.city)
                begin
                    $display("%0t: city expected %0d actual %0d",
                             $time, exp_beat.city, result.city);
                    errors++;
                end
                if (result.tour_cost !== exp_beat.tour_cost)
                begin
                    $display("%0t: tour_cost expected %0d actual %0d",
                             $time, exp_beat.tour_cost, result.tour_cost);
                    errors++;
                end
                if (result.last !== exp_beat.last)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, exp_beat.last, result.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic release_start();
        if (start_held)
        begin
            start <= 1'b0;
            start_held = 1'b0;
        end
    endtask

    task automatic gap_cycles();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) release_start();
        repeat (g) @(posedge clk);
    endtask

    task automatic send_beat(input tsp_in_t beat);
        start   <= 1'b1;
        in_item <= beat;
        start_held = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_tour(beat);
    endtask

    task automatic drain_tours();
        release_start();
        while (tour_beats_q.size() != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_city_count(input int n);
        drain_tours();
        cfg_we    <= 1'b1;
        cfg_wdata <= NCFG_W'(n);
        @(posedge clk);
        city_count_reg = NCFG_W'(n);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tsp_in_t wr_beat(int f, int t, int c);
        tsp_in_t b;
        b.command = CMD_WRITE; b.from_city = 3'(f); b.to_city = 3'(t); b.edge_cost = 16'(c);
        return b;
    endfunction

    function automatic tsp_in_t solve_beat();
        tsp_in_t b;
        b = tsp_in_t'(IN_W'($urandom()));
        b.command = CMD_SOLVE;
        return b;
    endfunction

    task automatic fill_matrix(input int mode);
        for (int f = 0; f < NMAX; f++)
            for (int t = 0; t < NMAX; t++)
            begin
                send_beat(wr_beat(f, t, mode == 0 ? 16'hFFFF :
                                        mode == 1 ? 16'h0000 : $urandom_range(0, 65535)));
                gap_cycles();
            end
    endtask

    initial
    begin
        vec_t  dir_tbl [$];
        vec_t  v;
        tsp_in_t b;
        int    sent;
        int    n;
        errors = 0;
        start_held = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        start = 1'b0;
        in_item = '0;
        city_count_reg = 8;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_matrix(0);
        set_city_count(1);
        v.beat = solve_beat(); v.has_fixed = 1; v.fixed_cost = 20'd65535;
        dir_tbl.push_back(v);
        v.beat = wr_beat(0, 0, 0); v.has_fixed = 0; dir_tbl.push_back(v);
        v.beat = solve_beat(); v.has_fixed = 1; v.fixed_cost = 20'd0;
        dir_tbl.push_back(v);
        v.beat = wr_beat(7, 7, 16'hFFFF); v.has_fixed = 0; dir_tbl.push_back(v);
        v.beat = wr_beat(0, 1, 16'h8001); dir_tbl.push_back(v);
        v.beat = wr_beat(1, 0, 16'h7FFE); dir_tbl.push_back(v);
        foreach (dir_tbl[i])
        begin
            send_beat(dir_tbl[i].beat);
            if (dir_tbl[i].has_fixed && tour_beats_q[$].tour_cost !== dir_tbl[i].fixed_cost)
            begin
                $display("%0t: fixed cost expected %0d actual %0d",
                         $time, dir_tbl[i].fixed_cost, tour_beats_q[$].tour_cost);
                errors++;
            end
        end
        set_city_count(2);
        send_beat(solve_beat());
        set_city_count(0);
        send_beat(solve_beat());
        set_city_count(15);
        fill_matrix(0);
        send_beat(solve_beat());
        set_city_count(8);
        send_beat(solve_beat());

        sent = 0;
        while (sent < 320)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8) : $urandom_range(1, 5);
            set_city_count(($urandom_range(0, 15) == 0) ? $urandom_range(9, 15) : n);
            n = eff_cities();
            repeat ($urandom_range(4, 16))
            begin
                b = tsp_in_t'(IN_W'($urandom()));
                b.command = CMD_WRITE;
                send_beat(b);
                gap_cycles();
                sent++;
            end
            for (int f = 0; f < n; f++)
                for (int t = 0; t < n; t++)
                    if (!cost_set[f][t] || $urandom_range(0, 2) == 0)
                    begin
                        send_beat(wr_beat(f, t, ($urandom_range(0, 7) == 0) ?
                                          16'hFFFF : $urandom_range(0, 300)));
                        gap_cycles();
                        sent++;
                    end
            repeat (n <= 5 ? $urandom_range(1, 3) : 1)
            begin
                send_beat(solve_beat());
                gap_cycles();
                sent++;
            end
            if ($urandom_range(0, 7) == 0) drain_tours();
        end

        drain_tours();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
